// ===== design/icmp_echo_request_builder_unit_assert.svh =====
// Assertion macros shared by the echo request builder modules.
`ifndef ICMP_ECHO_REQUEST_BUILDER_UNIT_ASSERT_SVH
`define ICMP_ECHO_REQUEST_BUILDER_UNIT_ASSERT_SVH

// Check on every rising edge, held off while reset is applied.
`define ERB_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every rising edge, reset included.
`define ERB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/icmp_erb_pkg.sv =====
// Types and constants shared by the echo request builder modules.
package icmp_erb_pkg;

  localparam int MAX_PACKET_BYTES = 256;
  localparam int HDR_BYTES        = 8;
  localparam int LEN_W            = 9;
  localparam int ID_W             = 16;
  localparam int SEQ_W            = 16;
  localparam int WORD_W           = 64;
  localparam int CNT_W            = 4;
  localparam int CFG_IDX_W        = 4;
  localparam int CFG_DATA_W       = 16;
  localparam int ACC_W            = 24;
  localparam int LETTER_W         = 5;
  localparam int ALPHABET         = 26;

  localparam logic [ID_W-1:0]  ECHO_ID_RESET   = 16'd12345;
  localparam logic [LEN_W-1:0] PKT_BYTES_RESET = 9'd64;
  localparam logic [7:0]       ICMP_TYPE_ECHO  = 8'd8;
  localparam logic [7:0]       ICMP_CODE_ECHO  = 8'd0;
  localparam logic [7:0]       CHAR_A          = 8'h41;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ECHO_IDENTIFIER = 4'd0,
    CFG_PACKET_BYTES    = 4'd1
  } cfg_reg_t;

  typedef struct packed {
    logic load;     // latch a new transaction
    logic acc_en;   // add one payload word to the checksum
    logic fold_en;  // fold the sum and rewind for output
    logic out_en;   // emit one packet word
  } erb_cmd_t;

  typedef struct packed {
    logic rem_zero;   // no bytes left in the current pass
    logic word_last;  // current word is the final one
  } erb_status_t;

endpackage

// ===== design/icmp_erb_ctrl.sv =====
// Sequencing controller for the echo request builder.
`include "icmp_echo_request_builder_unit_assert.svh"

module icmp_erb_ctrl
  import icmp_erb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  erb_status_t status,
  output erb_cmd_t    cmd,
  output logic        busy
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SUM  = 4'b0010,
    ST_FOLD = 4'b0100,
    ST_EMIT = 4'b1000
  } erb_state_t;

  erb_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        if (status.rem_zero) begin
          state_nxt = ST_FOLD;
        end else begin
          cmd.acc_en = 1'b1;
        end
      end
      ST_FOLD: begin
        cmd.fold_en = 1'b1;
        state_nxt   = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.out_en = 1'b1;
        if (status.word_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  `ERB_ASSERT_RUN(a_start_enters_sum,
    (state_r == ST_IDLE && start) |=> (state_r == ST_SUM),
    "accepted transaction did not start the checksum pass")
  `ERB_ASSERT_RUN(a_last_word_idles,
    (state_r == ST_EMIT && status.word_last) |=> (state_r == ST_IDLE),
    "controller kept emitting after the final word")
  `ERB_ASSERT_ALWAYS(a_fold_once,
    cmd.fold_en |-> (!cmd.acc_en && !cmd.out_en && !cmd.load),
    "fold issued together with another command")

endmodule

// ===== design/icmp_erb_dp.sv =====
// Datapath: configuration, checksum accumulator and packet word generation.
`include "icmp_echo_request_builder_unit_assert.svh"

module icmp_erb_dp
  import icmp_erb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [SEQ_W-1:0]      in_sequence_number,
  input  erb_cmd_t              cmd,
  output erb_status_t           status,
  output logic                  out_valid,
  output logic [WORD_W-1:0]     out_packet_word,
  output logic [CNT_W-1:0]      out_byte_count,
  output logic                  out_last_word
);

  logic [ID_W-1:0]     id_cfg_r;
  logic [LEN_W-1:0]    len_cfg_r;
  logic [ID_W-1:0]     id_r;
  logic [SEQ_W-1:0]    seq_r;
  logic [LEN_W-1:0]    len_r;
  logic [LEN_W-1:0]    rem_r;
  logic [LETTER_W-1:0] letter_r;
  logic [ACC_W-1:0]    acc_r;
  logic [15:0]         ck_r;
  logic                hdr_r;
  logic                out_valid_r;
  logic [WORD_W-1:0]   out_word_r;
  logic [CNT_W-1:0]    out_count_r;
  logic                out_last_r;

  logic [LEN_W-1:0]    eff_len;
  logic [LEN_W-1:0]    rem_step;
  logic [LETTER_W-1:0] letter_adv;
  logic [5:0]          letter_sum;
  logic [WORD_W-1:0]   pay_word;
  logic [WORD_W-1:0]   hdr_word;
  logic [17:0]         pair_sum;
  logic [16:0]         fold1;
  logic [15:0]         fold2;
  logic [5:0]          lane_idx [8];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_cfg_r  <= ECHO_ID_RESET;
      len_cfg_r <= PKT_BYTES_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_ECHO_IDENTIFIER) begin
        id_cfg_r <= cfg_wdata[ID_W-1:0];
      end else if (cfg_index == CFG_PACKET_BYTES) begin
        len_cfg_r <= cfg_wdata[LEN_W-1:0];
      end
    end
  end

  // Clamp the length to the header and the packet buffer
  always_comb begin
    if (len_cfg_r < LEN_W'(HDR_BYTES)) begin
      eff_len = LEN_W'(HDR_BYTES);
    end else if (len_cfg_r > LEN_W'(MAX_PACKET_BYTES)) begin
      eff_len = LEN_W'(MAX_PACKET_BYTES);
    end else begin
      eff_len = len_cfg_r;
    end
  end

  assign rem_step = (rem_r <= LEN_W'(8)) ? '0 : rem_r - LEN_W'(8);

  always_comb begin
    letter_sum = 6'(letter_r) + 6'd8;
    if (letter_sum >= 6'(ALPHABET)) begin
      letter_sum = letter_sum - 6'(ALPHABET);
    end
    letter_adv = letter_sum[LETTER_W-1:0];
  end

  // Payload lanes: letters wrap through the alphabet, zero past the end
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      lane_idx[b] = 6'(letter_r) + 6'(b);
      if (lane_idx[b] >= 6'(ALPHABET)) begin
        lane_idx[b] = lane_idx[b] - 6'(ALPHABET);
      end
      if (rem_r > LEN_W'(b)) begin
        pay_word[8*b +: 8] = CHAR_A + {3'b000, lane_idx[b][LETTER_W-1:0]};
      end else begin
        pay_word[8*b +: 8] = 8'h00;
      end
    end
  end

  // Big-endian 16-bit pairs of the payload word
  always_comb begin
    pair_sum = '0;
    for (int j = 0; j < 4; j++) begin
      pair_sum = pair_sum + 18'({pay_word[16*j +: 8], pay_word[16*j+8 +: 8]});
    end
  end

  assign hdr_word = {seq_r[7:0], seq_r[15:8], id_r[7:0], id_r[15:8],
                     ck_r[7:0], ck_r[15:8], ICMP_CODE_ECHO, ICMP_TYPE_ECHO};

  assign fold1 = {1'b0, acc_r[15:0]} + 17'(acc_r[ACC_W-1:16]);
  assign fold2 = fold1[15:0] + 16'(fold1[16]);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      id_r     <= id_cfg_r;
      seq_r    <= in_sequence_number;
      len_r    <= eff_len;
      rem_r    <= eff_len - LEN_W'(HDR_BYTES);
      letter_r <= '0;
      acc_r    <= ACC_W'({ICMP_TYPE_ECHO, ICMP_CODE_ECHO}) + ACC_W'(id_cfg_r)
                  + ACC_W'(in_sequence_number);
    end
    if (cmd.acc_en) begin
      acc_r    <= acc_r + ACC_W'(pair_sum);
      rem_r    <= rem_step;
      letter_r <= letter_adv;
    end
    if (cmd.fold_en) begin
      ck_r     <= ~fold2;
      rem_r    <= len_r;
      letter_r <= '0;
      hdr_r    <= 1'b1;
    end
    if (cmd.out_en) begin
      out_word_r  <= hdr_r ? hdr_word : pay_word;
      out_count_r <= (rem_r >= LEN_W'(8)) ? CNT_W'(8) : rem_r[CNT_W-1:0];
      out_last_r  <= (rem_r <= LEN_W'(8));
      rem_r       <= rem_step;
      hdr_r       <= 1'b0;
      if (!hdr_r) begin
        letter_r <= letter_adv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.out_en;
    end
  end

  assign status.rem_zero  = (rem_r == '0);
  assign status.word_last = (rem_r <= LEN_W'(8));

  assign out_valid       = out_valid_r;
  assign out_packet_word = out_word_r;
  assign out_byte_count  = out_count_r;
  assign out_last_word   = out_last_r;

  `ERB_ASSERT_RUN(a_words_contiguous,
    (out_valid_r && !out_last_r) |=> out_valid_r,
    "gap between words of one packet")
  `ERB_ASSERT_RUN(a_gap_after_last,
    (out_valid_r && out_last_r) |=> !out_valid_r,
    "word strobed right after the final word")
  `ERB_ASSERT_RUN(a_short_only_last,
    (out_valid_r && out_count_r != CNT_W'(8)) |-> out_last_r,
    "partial word that is not the final word")

endmodule

// ===== design/icmp_echo_request_builder_unit.sv =====
// Sequence after start is taken: load, checksum pass, fold, then emit registered words.
// A new start is taken only once the controller is idle after the final word is issued.
// The serial checksum pass, one 8-byte word a cycle, runs before the header word goes out.
// Words then stream on consecutive cycles; the receiver cannot stall.
// Synchronous active-low reset: identifier 12345, length 64, controller idle, no strobe.
module icmp_echo_request_builder_unit
  import icmp_erb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [SEQ_W-1:0]      in_sequence_number,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                  out_valid,
  output logic [WORD_W-1:0]     out_packet_word,
  output logic [CNT_W-1:0]      out_byte_count,
  output logic                  out_last_word
);

  erb_cmd_t    cmd;
  erb_status_t status;

  icmp_erb_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  icmp_erb_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_sequence_number (in_sequence_number),
    .cmd                (cmd),
    .status             (status),
    .out_valid          (out_valid),
    .out_packet_word    (out_packet_word),
    .out_byte_count     (out_byte_count),
    .out_last_word      (out_last_word)
  );

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the ICMP echo request builder: directed table, then random phases.
module testbench;
  import icmp_erb_pkg::*;

  localparam int WATCHDOG_CYCLES = 5000;
  localparam int TAIL_CYCLES     = 40;
  localparam int PHASES          = 7;
  localparam int ITEMS_PER_PHASE = 28;
  localparam int N_DIRECTED      = 29;

  // Indexes past the register list; the block must ignore writes to them.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LOW  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HIGH = 4'd15;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [CNT_W-1:0]  count;
    logic              last;
  } echo_word_t;

  typedef struct packed {
    logic       typed;
    echo_word_t word;
  } row_check_t;

  typedef enum logic [0:0] {ROW_WRITE, ROW_SEND} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [SEQ_W-1:0]      seq;
    logic                  typed;
    echo_word_t            word;
  } dir_row_t;

  localparam echo_word_t NO_WORD = '0;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [SEQ_W-1:0]      in_sequence_number;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  out_valid;
  logic [WORD_W-1:0]     out_packet_word;
  logic [CNT_W-1:0]      out_byte_count;
  logic                  out_last_word;

  echo_word_t     expected_words [$];
  row_check_t     row_checks [$];
  int             words_due;
  int             quiet_cycles;
  int             mismatch_count;
  logic [ID_W-1:0]  id_shadow;
  logic [LEN_W-1:0] len_shadow;
  dir_row_t       directed_rows [0:N_DIRECTED-1];

  icmp_echo_request_builder_unit u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_sequence_number (in_sequence_number),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .out_valid          (out_valid),
    .out_packet_word    (out_packet_word),
    .out_byte_count     (out_byte_count),
    .out_last_word      (out_last_word)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Build one echo request and queue its words; returns the number of words.
  function automatic int queue_echo_words(input logic [ID_W-1:0] ident,
                                          input logic [LEN_W-1:0] len_reg,
                                          input logic [SEQ_W-1:0] seq);
    logic [7:0]        pkt [MAX_PACKET_BYTES];
    int                n;
    int                nwords;
    int                b;
    int                k;
    int                cnt;
    logic [31:0]       sum;
    logic [15:0]       csum;
    echo_word_t        w;
    n = int'(len_reg);
    if (n < HDR_BYTES) n = HDR_BYTES;
    if (n > MAX_PACKET_BYTES) n = MAX_PACKET_BYTES;
    for (b = 0; b < MAX_PACKET_BYTES; b++) pkt[b] = 8'h00;
    pkt[0] = ICMP_TYPE_ECHO;
    pkt[1] = ICMP_CODE_ECHO;
    pkt[4] = ident[15:8];
    pkt[5] = ident[7:0];
    pkt[6] = seq[15:8];
    pkt[7] = seq[7:0];
    for (b = HDR_BYTES; b < n; b++) pkt[b] = CHAR_A + 8'((b - HDR_BYTES) % ALPHABET);
    // Sum big-endian pairs with the checksum field still zero; pad an odd tail.
    sum = '0;
    for (b = 0; b < n; b += 2)
      sum += {16'h0000, pkt[b], (b + 1 < n) ? pkt[b + 1] : 8'h00};
    sum = (sum >> 16) + (sum & 32'h0000_FFFF);
    sum = sum + (sum >> 16);
    csum = ~sum[15:0];
    pkt[2] = csum[15:8];
    pkt[3] = csum[7:0];
    nwords = (n + 7) / 8;
    for (k = 0; k < nwords; k++) begin
      cnt = n - 8 * k;
      if (cnt > 8) cnt = 8;
      w = '0;
      for (b = 0; b < cnt; b++) w.word[8*b +: 8] = pkt[8*k + b];
      w.count = CNT_W'(cnt);
      w.last  = (k + 1 == nwords);
      expected_words.push_back(w);
    end
    return nwords;
  endfunction

  // Mirror the registers, predict on every accepted request, check every word.
  always @(posedge clk) begin
    int         n_new;
    row_check_t row;
    echo_word_t got;
    echo_word_t want;
    if (!rst_n) begin
      words_due    <= 0;
      quiet_cycles <= 0;
      id_shadow    <= ECHO_ID_RESET;
      len_shadow   <= PKT_BYTES_RESET;
    end else begin
      n_new = 0;
      if (cfg_we) begin
        case (cfg_index)
          CFG_ECHO_IDENTIFIER: id_shadow  <= cfg_wdata;
          CFG_PACKET_BYTES:    len_shadow <= cfg_wdata[LEN_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        row = row_checks.pop_front();
        if (row.typed) begin
          expected_words.push_back(row.word);
          n_new = 1;
        end else begin
          n_new = queue_echo_words(id_shadow, len_shadow, in_sequence_number);
        end
      end
      if (out_valid) begin
        got = '{out_packet_word, out_byte_count, out_last_word};
        if (expected_words.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected packet word %h count %0d last %0b",
                     got.word, got.count, got.last);
          mismatch_count++;
        end else begin
          want = expected_words.pop_front();
          if (got.word !== want.word || got.count !== want.count ||
              got.last !== want.last) begin
            if (mismatch_count < 10)
              $display("word mismatch: expected %h/%0d/%0b got %h/%0d/%0b",
                       want.word, want.count, want.last, got.word, got.count, got.last);
            mismatch_count++;
          end
        end
      end
      words_due <= words_due + n_new - (out_valid ? 1 : 0);
      if ((start && !busy) || out_valid || cfg_we)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Hold start until the block takes the transaction; start stays high afterwards.
  task automatic issue_request(input logic [SEQ_W-1:0] seq, input logic typed,
                               input echo_word_t word);
    row_checks.push_back('{typed, word});
    start              <= 1'b1;
    in_sequence_number <= seq;
    do @(posedge clk); while (busy);
  endtask

  // Drop start and wait until every queued word has come out and the block is idle.
  task automatic drain_block();
    start <= 1'b0;
    do @(posedge clk); while (words_due != 0 || busy);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic maybe_idle();
    if ($urandom_range(0, 99) < 8) begin
      start              <= 1'b0;
      in_sequence_number <= SEQ_W'($urandom);
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  initial begin
    int               i;
    int               p;
    int               k;
    int               r;
    logic [LEN_W-1:0] len;
    logic             quiet;
    rst_n              = 1'b0;
    start              = 1'b0;
    in_sequence_number = '0;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_wdata          = '0;
    mismatch_count     = 0;

    directed_rows = '{
      '{ROW_SEND,  CFG_ECHO_IDENTIFIER, 16'h0000, 16'h0000, 1'b0, NO_WORD},
      '{ROW_SEND,  CFG_ECHO_IDENTIFIER, 16'h0000, 16'hFFFF, 1'b0, NO_WORD},
      '{ROW_WRITE, CFG_PACKET_BYTES,    16'd8,    16'h0000, 1'b0, NO_WORD},
      '{ROW_WRITE, CFG_ECHO_IDENTIFIER, 16'h0000, 16'h0000, 1'b0, NO_WORD},
      // header only, zero identifier and sequence
      '{ROW_SEND,  CFG_ECHO_IDENTIFIER, 16'h0000, 16'h0000, 1'b1,
        '{64'h0000_0000_FFF7_0008, 4'd8, 1'b1}},
      '{ROW_WRITE, CFG_ECHO_IDENTIFIER, 16'hFFFF, 16'h0000, 1'b0, NO_WORD},
      // header only, all-ones identifier and sequence: end-around carry
      '{ROW_SEND,  CFG_ECHO_IDENTIFIER, 16'h0000, 16'hFFFF, 1'b1,
        '{64'hFFFF_FFFF_FFF7_0008, 4'd8, 1'b1}},
      '{ROW_WRITE, CFG_PACKET_BYTES,    16'd0,    16'h0000, 1'b0, NO_WORD},
      '{ROW_SEND,  CFG_ECHO_IDENTIFIER, 16'h0000, 16'h1234, 1'b0, NO_WORD},
      '{ROW_WRITE, CFG_PACKET_BYTES,    16'd7,    16'h0000, 1'b0, NO_WORD},
      '{ROW_SEND,  CFG_ECHO_IDENTIFIER, 16'h0000, 16'hA5A5, 1'b0, NO_WORD},
      '{ROW_WRITE, CFG_PACKET_BYTES,    16'd9,    16'h0000, 1'b0, NO_WORD},
      '{ROW_SEND,  CFG_ECHO_IDENTIFIER, 16'h0000, 16'h5A5A, 1'b0, NO_WORD},
      '{ROW_WRITE, CFG_PACKET_BYTES,    16'd511,  16'h0000, 1'b0, NO_WORD},
      '{ROW_SEND,  CFG_ECHO_IDENTIFIER, 16'h0000, 16'h0001, 1'b0, NO_WORD},
      '{ROW_WRITE, CFG_PACKET_BYTES,    16'd257,  16'h0000, 1'b0, NO_WORD},
      '{ROW_SEND,  CFG_ECHO_IDENTIFIER, 16'h0000, 16'h8000, 1'b0, NO_WORD},
      '{ROW_WRITE, CFG_PACKET_BYTES,    16'd256,  16'h0000, 1'b0, NO_WORD},
      '{ROW_SEND,  CFG_ECHO_IDENTIFIER, 16'h0000, 16'h7FFF, 1'b0, NO_WORD},
      '{ROW_WRITE, CFG_ECHO_IDENTIFIER, 16'h8001, 16'h0000, 1'b0, NO_WORD},
      '{ROW_WRITE, CFG_PACKET_BYTES,    16'd255,  16'h0000, 1'b0, NO_WORD},
      '{ROW_SEND,  CFG_ECHO_IDENTIFIER, 16'h0000, 16'hFF00, 1'b0, NO_WORD},
      '{ROW_WRITE, CFG_SPARE_HIGH,      16'h0010, 16'h0000, 1'b0, NO_WORD},
      '{ROW_SEND,  CFG_ECHO_IDENTIFIER, 16'h0000, 16'h00FF, 1'b0, NO_WORD},
      '{ROW_WRITE, CFG_SPARE_LOW,       16'hFFFF, 16'h0000, 1'b0, NO_WORD},
      '{ROW_SEND,  CFG_ECHO_IDENTIFIER, 16'h0000, 16'h0F0F, 1'b0, NO_WORD},
      '{ROW_WRITE, CFG_PACKET_BYTES,    16'd13,   16'h0000, 1'b0, NO_WORD},
      '{ROW_SEND,  CFG_ECHO_IDENTIFIER, 16'h0000, 16'hC3C3, 1'b0, NO_WORD},
      '{ROW_SEND,  CFG_ECHO_IDENTIFIER, 16'h0000, 16'h3C3C, 1'b0, NO_WORD}
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < N_DIRECTED; i++) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        drain_block();
        write_register(directed_rows[i].idx, directed_rows[i].data);
      end else begin
        issue_request(directed_rows[i].seq, directed_rows[i].typed, directed_rows[i].word);
      end
    end

    for (p = 0; p < PHASES; p++) begin
      drain_block();
      r = $urandom_range(0, 9);
      if (r < 6)      len = LEN_W'($urandom_range(8, 64));
      else if (r < 8) len = LEN_W'($urandom_range(65, 256));
      else            len = LEN_W'($urandom_range(0, 511));
      if ($urandom_range(0, 1)) begin
        write_register(CFG_ECHO_IDENTIFIER, CFG_DATA_W'($urandom));
        write_register(CFG_PACKET_BYTES, CFG_DATA_W'(len));
      end else begin
        write_register(CFG_PACKET_BYTES, CFG_DATA_W'(len));
        write_register(CFG_ECHO_IDENTIFIER, CFG_DATA_W'($urandom));
      end
      if ($urandom_range(0, 9) < 3)
        write_register(CFG_IDX_W'($urandom_range(CFG_SPARE_LOW, CFG_SPARE_HIGH)),
                       CFG_DATA_W'($urandom));
      // One phase runs back to back with no gaps at all.
      quiet = (p == 2);
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (!quiet) begin
          maybe_idle();
          if ($urandom_range(0, 99) < 3) drain_block();
        end
        issue_request(SEQ_W'($urandom), 1'b0, NO_WORD);
      end
    end

    drain_block();
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatch_count == 0 && expected_words.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ===== icmp_echo_request_builder_unit.f =====
+incdir+design
design/icmp_erb_pkg.sv
design/icmp_erb_ctrl.sv
design/icmp_erb_dp.sv
design/icmp_echo_request_builder_unit.sv
sim/testbench.sv
